// ===== hdl/bsa_pkg.sv =====
// bsa_pkg: shared types, constants and codes of the bitmap slot allocator
// used by bitmap_slot_allocator and by the testbench; no dependencies
package bsa_pkg;

  localparam int WORD_BITS  = 64;
  localparam int MAX_WORDS  = 256;
  localparam int BIT_IDX_W  = $clog2(WORD_BITS);
  localparam int WORD_IDX_W = $clog2(MAX_WORDS);
  localparam int NW_W       = $clog2(MAX_WORDS + 1);
  localparam int SLOT_W     = 14;
  localparam int CNT_W      = 15;
  localparam int CFG_W      = 9;

  localparam logic [CNT_W-1:0] COUNT_MAX = CNT_W'(1 << SLOT_W);

  typedef enum logic [1:0] {
    OP_ALLOC = 2'd0,
    OP_SET   = 2'd1,
    OP_CLEAR = 2'd2,
    OP_TEST  = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_RANGE = 2'd2
  } status_t;

  typedef struct packed {
    logic [1:0]        op;
    logic [SLOT_W-1:0] slot;
  } req_t;

  typedef struct packed {
    logic [SLOT_W-1:0] result_slot;
    logic              bit_value;
    logic [1:0]        status;
    logic [CNT_W-1:0]  used_count;
  } rsp_t;

  // index of the lowest clear bit of a word
  function automatic logic [BIT_IDX_W-1:0] lowest_zero(input logic [WORD_BITS-1:0] w);
    logic [BIT_IDX_W-1:0] idx;
    idx = '0;
    for (int i = WORD_BITS - 1; i >= 0; i--) begin
      if (!w[i]) idx = BIT_IDX_W'(i);
    end
    return idx;
  endfunction

endpackage

// ===== hdl/bsa_ram.sv =====
// bsa_ram: generic single write port, single read port ram with registered read
// no dependencies
module bsa_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end

endmodule

// ===== hdl/bitmap_slot_allocator.sv =====
// bitmap_slot_allocator: slot-use bitmap with set, clear, test and allocate
// depends on bsa_pkg and bsa_ram
//
// sequence: set, clear, test and a free suggestion finish in the execute state,
//   with done registered from it; a busy suggestion first scans up to words_in_use
//   word-full flags, then, if a word is not full, reads it and picks its lowest clear bit
// requests: no new request is taken until busy falls, as each request holds the block
//   through the read-modify-write of its word in the ram; allocate scans one word-full flag per cycle
// reset: all slots free at once through per-word valid flags, count zero,
//   words_in_use 256; results cannot be stalled, done lasts one cycle
module bitmap_slot_allocator
  import bsa_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  req_t             req,
  output logic             busy,
  output logic             done,
  output rsp_t             rsp,
  input  logic             cfg_we,
  input  logic [CFG_W-1:0] cfg_wdata
);

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_EXEC = 4'b0010,
    S_SCAN = 4'b0100,
    S_FIND = 4'b1000
  } state_t;

  state_t state, state_next;

  logic [NW_W-1:0]       nw;
  logic [CNT_W-1:0]      used_total;
  logic [MAX_WORDS-1:0]  valid;
  logic [MAX_WORDS-1:0]  full;
  logic                  rd_valid;

  logic [1:0]            op_q;
  logic [SLOT_W-1:0]     slot_q;
  logic [SLOT_W-1:0]     eff_q;
  logic                  range_err_q;
  logic [WORD_IDX_W-1:0] widx;
  logic [NW_W-1:0]       scan_cnt;

  logic [CNT_W-1:0]      cap;
  logic                  in_oor;
  logic [SLOT_W-1:0]     in_eff;
  logic [WORD_IDX_W-1:0] raddr;
  logic [WORD_BITS-1:0]  ram_rdata;
  logic [WORD_BITS-1:0]  rword;
  logic [WORD_BITS-1:0]  wword;
  logic [WORD_BITS-1:0]  bit_mask;
  logic                  we;
  logic [WORD_IDX_W-1:0] eff_word;
  logic [BIT_IDX_W-1:0]  eff_bit;
  logic                  cur_bit;

  assign cap      = CNT_W'(nw) << BIT_IDX_W;
  assign in_oor   = {1'b0, req.slot} >= cap;
  assign in_eff   = (op_t'(req.op) == OP_ALLOC && in_oor) ? '0 : req.slot;
  assign eff_word = eff_q[BIT_IDX_W +: WORD_IDX_W];
  assign eff_bit  = eff_q[BIT_IDX_W-1:0];
  assign rword    = rd_valid ? ram_rdata : '0;
  assign cur_bit  = rword[eff_bit];
  assign bit_mask = WORD_BITS'(1) << eff_bit;
  assign wword    = (op_t'(op_q) == OP_SET) ? (rword | bit_mask) : (rword & ~bit_mask);
  assign we       = state == S_EXEC && !range_err_q
                    && (op_t'(op_q) == OP_SET || op_t'(op_q) == OP_CLEAR);
  assign busy     = state != S_IDLE;

  always_comb begin
    if (state == S_SCAN) raddr = widx;
    else                 raddr = in_eff[BIT_IDX_W +: WORD_IDX_W];
  end

  bsa_ram #(.WIDTH(WORD_BITS), .DEPTH(MAX_WORDS)) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (eff_word),
    .wdata (wword),
    .raddr (raddr),
    .rdata (ram_rdata)
  );

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: if (start) state_next = S_EXEC;
      S_EXEC: begin
        if (op_t'(op_q) == OP_ALLOC && cur_bit) state_next = S_SCAN;
        else                                   state_next = S_IDLE;
      end
      S_SCAN: begin
        if (!full[widx])                               state_next = S_FIND;
        else if (NW_W'(scan_cnt + NW_W'(1)) == nw)     state_next = S_IDLE;
      end
      S_FIND: state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      nw         <= NW_W'(MAX_WORDS);
      used_total <= '0;
      valid      <= '0;
      full       <= '0;
      done       <= 1'b0;
      rd_valid   <= 1'b0;
    end else begin
      state    <= state_next;
      done     <= 1'b0;
      rd_valid <= valid[raddr];

      if (cfg_we) begin
        if (cfg_wdata == '0)                  nw <= NW_W'(1);
        else if (cfg_wdata > CFG_W'(MAX_WORDS)) nw <= NW_W'(MAX_WORDS);
        else                                   nw <= NW_W'(cfg_wdata);
      end

      if (we) begin
        valid[eff_word] <= 1'b1;
        full[eff_word]  <= &wword;
      end

      case (state)
        S_EXEC: begin
          if (!(op_t'(op_q) == OP_ALLOC && cur_bit)) done <= 1'b1;
          if (!range_err_q && op_t'(op_q) == OP_SET && used_total < COUNT_MAX)
            used_total <= used_total + CNT_W'(1);
          if (!range_err_q && op_t'(op_q) == OP_CLEAR && used_total != '0)
            used_total <= used_total - CNT_W'(1);
        end
        S_SCAN: if (full[widx] && NW_W'(scan_cnt + NW_W'(1)) == nw) done <= 1'b1;
        S_FIND: done <= 1'b1;
        default: ;
      endcase
    end
  end

  // request capture, scan pointer and result payload
  always_ff @(posedge clk) begin
    if (state == S_IDLE && start) begin
      op_q        <= req.op;
      slot_q      <= req.slot;
      eff_q       <= in_eff;
      range_err_q <= op_t'(req.op) != OP_ALLOC && in_oor;
    end

    case (state)
      S_EXEC: begin
        widx     <= eff_word;
        scan_cnt <= '0;
        rsp.result_slot <= (op_t'(op_q) == OP_ALLOC) ? eff_q : slot_q;
        rsp.bit_value   <= range_err_q ? 1'b0 : cur_bit;
        rsp.status      <= range_err_q ? ST_RANGE : ST_OK;
        if (!range_err_q && op_t'(op_q) == OP_SET)
          rsp.used_count <= (used_total < COUNT_MAX) ? used_total + CNT_W'(1) : used_total;
        else if (!range_err_q && op_t'(op_q) == OP_CLEAR)
          rsp.used_count <= (used_total != '0) ? used_total - CNT_W'(1) : used_total;
        else
          rsp.used_count <= used_total;
      end
      S_SCAN: begin
        if (full[widx]) begin
          // wrap at the active word count
          if (NW_W'(widx) + NW_W'(1) == nw) widx <= '0;
          else                                widx <= widx + WORD_IDX_W'(1);
          scan_cnt <= scan_cnt + NW_W'(1);
        end
        rsp.result_slot <= slot_q;
        rsp.bit_value   <= 1'b1;
        rsp.status      <= ST_FULL;
      end
      S_FIND: begin
        rsp.result_slot <= SLOT_W'({widx, lowest_zero(rword)});
        rsp.status      <= ST_OK;
      end
      default: ;
    endcase
  end

  a_done_after_work: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(state) != S_IDLE)
    else $error("result strobe without a request in progress");

  a_count_limit: assert property (@(posedge clk) disable iff (rst)
    used_total <= COUNT_MAX)
    else $error("used count beyond capacity");

  a_full_only_alloc: assert property (@(posedge clk) disable iff (rst)
    (done && rsp.status == ST_FULL) |-> op_t'(op_q) == OP_ALLOC)
    else $error("map full reported for a non-allocate request");

  a_scan_bound: assert property (@(posedge clk) disable iff (rst)
    state == S_SCAN |-> (scan_cnt < nw && NW_W'(widx) < nw))
    else $error("scan left the active words");

  a_find_has_free: assert property (@(posedge clk) disable iff (rst)
    state == S_FIND |-> !(&rword))
    else $error("found word has no free bit");

endmodule

// ===== sim/testbench.sv =====
`timescale 1ns / 100ps
// testbench: self-checking bench for bitmap_slot_allocator, driving requests and checking every
// response against an in-bench model or a directed expected value; depends on bsa_pkg and bitmap_slot_allocator
module testbench;
  import bsa_pkg::*;

  typedef enum logic [1:0] {
    ROW_REQ,
    ROW_CFG,
    ROW_FILL
  } row_kind_t;

  typedef struct {
    row_kind_t         kind;
    op_t               op;
    logic [SLOT_W-1:0] slot;   // slot, register value or word to fill
    bit                typed;
    rsp_t              want;
  } dir_row_t;

  logic             clk = 1'b0;
  logic             rst;
  logic             start;
  req_t             req;
  logic             busy;
  logic             done;
  rsp_t             rsp;
  logic             cfg_we;
  logic [CFG_W-1:0] cfg_wdata;

  // model state
  logic [WORD_BITS-1:0] slot_map [0:MAX_WORDS-1];
  logic [CNT_W-1:0]     slots_used;
  logic [CFG_W-1:0]     words_cfg;

  rsp_t        pending_rsp [$];
  dir_row_t    dir_rows [$];
  int unsigned gap_pct;
  int unsigned n_req, n_rsp, n_err, n_full, n_range, n_cfg;

  bitmap_slot_allocator u_top (
    .clk      (clk),
    .rst      (rst),
    .start    (start),
    .req      (req),
    .busy     (busy),
    .done     (done),
    .rsp      (rsp),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  function automatic int unsigned active_words();
    if (words_cfg == 0) return 1;
    if (words_cfg > MAX_WORDS) return MAX_WORDS;
    return words_cfg;
  endfunction

  // response of one request, updating the model bitmap and count
  function automatic rsp_t next_response(input req_t r);
    rsp_t        o;
    int unsigned nw, cap, s, w, b, n;
    bit          found;
    nw  = active_words();
    cap = nw * WORD_BITS;
    o.result_slot = r.slot;
    o.bit_value   = 1'b0;
    o.status      = ST_OK;
    if (op_t'(r.op) == OP_ALLOC) begin
      s = (r.slot >= cap) ? 0 : r.slot;
      o.bit_value = slot_map[s / WORD_BITS][s % WORD_BITS];
      if (!o.bit_value) begin
        o.result_slot = SLOT_W'(s);
      end else begin
        w = s / WORD_BITS;
        found = 1'b0;
        n = 0;
        // circular scan from the suggestion's word
        while (!found && n < nw) begin
          if (slot_map[w] != '1) begin
            found = 1'b1;
          end else begin
            w = (w + 1) % nw;
            n++;
          end
        end
        if (found) begin
          b = 0;
          while (slot_map[w][b]) b++;
          o.result_slot = SLOT_W'(w * WORD_BITS + b);
        end else begin
          o.status = ST_FULL;
        end
      end
    end else if (r.slot >= cap) begin
      o.status = ST_RANGE;
    end else begin
      w = r.slot / WORD_BITS;
      b = r.slot % WORD_BITS;
      o.bit_value = slot_map[w][b];
      if (op_t'(r.op) == OP_SET) begin
        slot_map[w][b] = 1'b1;
        if (slots_used < COUNT_MAX) slots_used++;
      end else if (op_t'(r.op) == OP_CLEAR) begin
        slot_map[w][b] = 1'b0;
        if (slots_used > 0) slots_used--;
      end
    end
    o.used_count = slots_used;
    return o;
  endfunction

  function automatic rsp_t make_rsp(input int unsigned rslot, input bit bitv,
                                    input status_t st, input int unsigned cnt);
    rsp_t o;
    o.result_slot = SLOT_W'(rslot);
    o.bit_value   = bitv;
    o.status      = st;
    o.used_count  = CNT_W'(cnt);
    return o;
  endfunction

  function automatic dir_row_t row(input row_kind_t kind, input op_t op,
                                   input int unsigned slot, input bit typed,
                                   input rsp_t want);
    dir_row_t d;
    d.kind  = kind;
    d.op    = op;
    d.slot  = SLOT_W'(slot);
    d.typed = typed;
    d.want  = want;
    return d;
  endfunction

  // inputs change on the falling edge; acceptance is seen at the rising edge
  task automatic issue(input op_t op, input logic [SLOT_W-1:0] slot, input bit typed,
                       input rsp_t want, output rsp_t got);
    req_t r;
    r.op   = op;
    r.slot = slot;
    while ($urandom_range(99) < gap_pct) begin
      start <= 1'b0;
      @(negedge clk);
    end
    start <= 1'b1;
    req   <= r;
    @(posedge clk);
    while (busy) @(posedge clk);
    got = next_response(r);
    pending_rsp.push_back(typed ? want : got);
    n_req++;
    @(negedge clk);
  endtask

  task automatic write_words(input logic [CFG_W-1:0] v);
    start <= 1'b0;
    while (pending_rsp.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(negedge clk);
    cfg_we    <= 1'b0;
    words_cfg = v;
    n_cfg++;
  endtask

  task automatic random_request();
    int unsigned cap, pick;
    rsp_t        got;
    cap  = active_words() * WORD_BITS;
    pick = $urandom_range(99);
    if (pick < 40) begin
      // allocate, then claim the offered slot
      issue(OP_ALLOC, (pick < 6) ? SLOT_W'($urandom_range(16383))
                                 : SLOT_W'($urandom_range(cap - 1)), 1'b0, '0, got);
      if (got.status == ST_OK) issue(OP_SET, got.result_slot, 1'b0, '0, got);
    end else if (pick < 60) begin
      issue(OP_CLEAR, SLOT_W'($urandom_range(cap - 1)), 1'b0, '0, got);
    end else if (pick < 70) begin
      issue(OP_TEST, SLOT_W'($urandom_range(cap - 1)), 1'b0, '0, got);
    end else if (pick < 80) begin
      issue(OP_SET, SLOT_W'($urandom_range(cap - 1)), 1'b0, '0, got);
    end else begin
      issue(op_t'($urandom_range(3)), SLOT_W'($urandom_range(16383)), 1'b0, '0, got);
    end
  endtask

  task automatic report_field(input string name, input logic [31:0] want,
                              input logic [31:0] seen);
    n_err++;
    if (n_err <= 40)
      $display("%0t ns: %s mismatch, expected %0d, got %0d", $time, name, want, seen);
  endtask

  always @(posedge clk) begin : check_rsp
    rsp_t want;
    if (!rst && done) begin
      n_rsp++;
      if (pending_rsp.size() == 0) begin
        n_err++;
        $display("%0t ns: response with no request waiting, expected none, got %h",
                 $time, rsp);
      end else begin
        want = pending_rsp.pop_front();
        if (want.status == ST_FULL) n_full++;
        if (want.status == ST_RANGE) n_range++;
        if (rsp.result_slot !== want.result_slot)
          report_field("result_slot", 32'(want.result_slot), 32'(rsp.result_slot));
        if (rsp.bit_value !== want.bit_value)
          report_field("bit_value", 32'(want.bit_value), 32'(rsp.bit_value));
        if (rsp.status !== want.status)
          report_field("status", 32'(want.status), 32'(rsp.status));
        if (rsp.used_count !== want.used_count)
          report_field("used_count", 32'(want.used_count), 32'(rsp.used_count));
      end
    end
  end

  initial begin
    #60_000_000;
    $display("Test completed with failures");
    $finish;
  end

  initial begin
    rsp_t        got;
    logic [CFG_W-1:0] v;
    rst       <= 1'b1;
    start     <= 1'b0;
    req       <= '0;
    cfg_we    <= 1'b0;
    cfg_wdata <= '0;
    for (int i = 0; i < MAX_WORDS; i++) slot_map[i] = '0;
    slots_used = '0;
    words_cfg  = 9'd256;
    gap_pct    = 0;

    // directed rows: capacity edges, range errors, full map, wrap-around
    dir_rows.push_back(row(ROW_REQ, OP_TEST, 0, 1, make_rsp(0, 0, ST_OK, 0)));
    dir_rows.push_back(row(ROW_REQ, OP_TEST, 16383, 1, make_rsp(16383, 0, ST_OK, 0)));
    dir_rows.push_back(row(ROW_REQ, OP_CLEAR, 5, 1, make_rsp(5, 0, ST_OK, 0)));
    dir_rows.push_back(row(ROW_REQ, OP_ALLOC, 16383, 1, make_rsp(16383, 0, ST_OK, 0)));
    dir_rows.push_back(row(ROW_REQ, OP_SET, 16383, 1, make_rsp(16383, 0, ST_OK, 1)));
    dir_rows.push_back(row(ROW_REQ, OP_SET, 16383, 1, make_rsp(16383, 1, ST_OK, 2)));
    dir_rows.push_back(row(ROW_REQ, OP_ALLOC, 16383, 1, make_rsp(16320, 1, ST_OK, 2)));
    dir_rows.push_back(row(ROW_REQ, OP_CLEAR, 100, 1, make_rsp(100, 0, ST_OK, 1)));
    dir_rows.push_back(row(ROW_CFG, OP_ALLOC, 0, 0, '0));
    dir_rows.push_back(row(ROW_REQ, OP_TEST, 64, 1, make_rsp(64, 0, ST_RANGE, 1)));
    dir_rows.push_back(row(ROW_REQ, OP_SET, 16383, 1, make_rsp(16383, 0, ST_RANGE, 1)));
    dir_rows.push_back(row(ROW_REQ, OP_CLEAR, 64, 1, make_rsp(64, 0, ST_RANGE, 1)));
    dir_rows.push_back(row(ROW_REQ, OP_ALLOC, 9000, 1, make_rsp(0, 0, ST_OK, 1)));
    dir_rows.push_back(row(ROW_FILL, OP_SET, 0, 0, '0));
    dir_rows.push_back(row(ROW_REQ, OP_ALLOC, 3, 1, make_rsp(3, 1, ST_FULL, 65)));
    dir_rows.push_back(row(ROW_REQ, OP_ALLOC, 12000, 1, make_rsp(12000, 1, ST_FULL, 65)));
    dir_rows.push_back(row(ROW_CFG, OP_ALLOC, 2, 0, '0));
    dir_rows.push_back(row(ROW_REQ, OP_ALLOC, 5, 1, make_rsp(64, 1, ST_OK, 65)));
    dir_rows.push_back(row(ROW_FILL, OP_SET, 1, 0, '0));
    dir_rows.push_back(row(ROW_REQ, OP_ALLOC, 127, 1, make_rsp(127, 1, ST_FULL, 129)));
    dir_rows.push_back(row(ROW_REQ, OP_CLEAR, 10, 1, make_rsp(10, 1, ST_OK, 128)));
    dir_rows.push_back(row(ROW_REQ, OP_ALLOC, 100, 1, make_rsp(10, 1, ST_OK, 128)));
    dir_rows.push_back(row(ROW_CFG, OP_ALLOC, 511, 0, '0));
    dir_rows.push_back(row(ROW_REQ, OP_TEST, 16383, 0, '0));
    dir_rows.push_back(row(ROW_REQ, OP_ALLOC, 16000, 0, '0));
    dir_rows.push_back(row(ROW_CFG, OP_ALLOC, 300, 0, '0));
    dir_rows.push_back(row(ROW_REQ, OP_ALLOC, 20, 0, '0));

    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    foreach (dir_rows[i]) begin
      case (dir_rows[i].kind)
        ROW_CFG: write_words(dir_rows[i].slot[CFG_W-1:0]);
        ROW_FILL: begin
          for (int b = 0; b < WORD_BITS; b++)
            issue(OP_SET, SLOT_W'(dir_rows[i].slot * WORD_BITS + b), 1'b0, '0, got);
        end
        default: issue(dir_rows[i].op, dir_rows[i].slot, dir_rows[i].typed,
                       dir_rows[i].want, got);
      endcase
    end

    // random phases: small capacities fill the map and force scans
    for (int ph = 0; ph < 8; ph++) begin
      case (ph)
        0: v = 9'd1;
        1: v = 9'd2;
        2: v = 9'd3;
        3: v = 9'd256;
        4: v = 9'd0;
        5: v = 9'd4;
        6: v = 9'd511;
        default: v = CFG_W'($urandom_range(5, 16));
      endcase
      write_words(v);
      gap_pct = (ph % 3 == 0) ? 0 : (ph % 3 == 1) ? 45 : 24;
      repeat (80) random_request();
    end

    // end on a single word so the map fills again under idle gaps
    write_words(9'd1);
    gap_pct = 24;
    repeat (60) random_request();

    start <= 1'b0;
    while (pending_rsp.size() != 0) @(negedge clk);
    repeat (MAX_WORDS + 8) @(negedge clk);

    $display("%0d requests sent, %0d responses checked over %0d capacity writes",
             n_req, n_rsp, n_cfg);
    $display("%0d map-full and %0d out-of-range responses seen", n_full, n_range);
    if (n_err == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
